>>> rtl/lsc_pkg.sv
// Shared types and constants of the LRU signature cache.
package lsc_pkg;

    localparam int NODE_W  = 16;
    localparam int BYTE_W  = 48;
    localparam int MM_W    = 16;
    localparam int STAMP_W = 64;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [NODE_W-1:0] nodes;
        logic [BYTE_W-1:0] live_bytes;
        logic [MM_W-1:0]   matmuls;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_UPDATE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    // Control of the scan unit for one cycle.
    typedef struct packed {
        logic clear;
        logic cmp;
    } t_scan_ctl;

endpackage

>>> rtl/lsc_if.sv
// Request and response stream interfaces of the LRU signature cache.
interface lsc_req_if import lsc_pkg::*; #(
    parameter int PAYLOAD_BITS = 64
) ();
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [NODE_W-1:0]       key_node_count;
    logic [BYTE_W-1:0]       key_live_bytes;
    logic [MM_W-1:0]         key_matmul_count;
    logic [PAYLOAD_BITS-1:0] payload_in;

    modport source (
        output valid, opcode, key_node_count, key_live_bytes, key_matmul_count, payload_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, key_node_count, key_live_bytes, key_matmul_count, payload_in,
        output ready
    );
endinterface

interface lsc_rsp_if import lsc_pkg::*; #(
    parameter int PAYLOAD_BITS = 64
) ();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [PAYLOAD_BITS-1:0] payload_out;
    logic [CNT_W-1:0]        hit_total;
    logic [CNT_W-1:0]        miss_total;

    modport source (
        output valid, found, payload_out, hit_total, miss_total,
        input  ready
    );
    modport sink (
        input  valid, found, payload_out, hit_total, miss_total,
        output ready
    );
endinterface

>>> rtl/lsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lsc_scan.sv
// Shared compare unit: key match and oldest-stamp search, one entry per cycle.
module lsc_scan import lsc_pkg::*; #(
    parameter int IW           = 4,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_scan_ctl               i_ctl,
    input  logic [IW-1:0]           i_idx,
    input  t_key                    i_key,
    input  t_key                    i_ent_key,
    input  logic [STAMP_W-1:0]      i_ent_stamp,
    input  logic [PAYLOAD_BITS-1:0] i_ent_payload,
    output logic                    o_found,
    output logic [IW-1:0]           o_hit_idx,
    output logic [PAYLOAD_BITS-1:0] o_hit_payload,
    output logic [IW-1:0]           o_victim_idx
);

    logic                    r_found;
    logic                    r_first;
    logic [IW-1:0]           r_hit_idx;
    logic [PAYLOAD_BITS-1:0] r_hit_payload;
    logic [STAMP_W-1:0]      r_min_stamp;
    logic [IW-1:0]           r_victim_idx;
    logic                    take_hit;
    logic                    take_min;

    // Only the first match counts; a strictly smaller stamp keeps the lowest index on ties.
    assign take_hit = i_ctl.cmp && !r_found && (i_ent_key == i_key);
    assign take_min = i_ctl.cmp && (r_first || (i_ent_stamp < r_min_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_first <= 1'b1;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
            r_first <= 1'b1;
        end else if (i_ctl.cmp) begin
            r_first <= 1'b0;
            if (take_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_hit) begin
            r_hit_idx     <= i_idx;
            r_hit_payload <= i_ent_payload;
        end
        if (take_min) begin
            r_min_stamp  <= i_ent_stamp;
            r_victim_idx <= i_idx;
        end
    end

    assign o_found       = r_found;
    assign o_hit_idx     = r_hit_idx;
    assign o_hit_payload = r_hit_payload;
    assign o_victim_idx  = r_victim_idx;

endmodule

>>> rtl/lru_signature_cache.sv
// Top level of the fully associative LRU signature cache.
//
// A fully associative cache of ENTRIES slots, keyed by a signature made of a node count,
// a live byte total and a matrix multiply count. Each request transaction is either a
// lookup or an update. A lookup returns found and the stored payload on a hit (zero on a
// miss) and bumps the saturating hit or miss counter; it never changes recency. An update
// whose key is present overwrites that payload and restamps the entry with the next tick;
// otherwise it fills the next free slot while the fill level is below the capacity in use
// (a write of 0 acts as 1, values above ENTRIES act as ENTRIES), or else replaces the
// entry with the smallest stamp, lowest index first on a tie. Lowering the capacity never
// drops entries that are already filled. Entries live in one RAM that is read one entry
// per cycle, and a single compare unit checks the key and tracks the oldest stamp in the
// same pass. After the scan the sequencer commits the result only once the output register
// is free, so a response that has not been taken holds the next one back. The block takes
// no new request while a transaction is in work. The response sits in an output register,
// so a new request can be accepted while the previous response waits to be taken. The user
// must write the capacity register through i_cfg_we and i_cfg_wdata only while idle; the
// block itself does not enforce it.
module lru_signature_cache import lsc_pkg::*; #(
    parameter int ENTRIES      = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    lsc_req_if.sink           i_req,
    lsc_rsp_if.source         o_rsp
);

    // Index width for the RAM and fill width that can hold ENTRIES itself.
    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW     = $clog2(ENTRIES + 1);
    localparam int CMPW   = (FW > CAP_W) ? FW : CAP_W;
    localparam int WORD_W = KEY_W + STAMP_W + PAYLOAD_BITS;

    // Sequencer state.
    t_state r_state;
    t_state n_state;

    // Scan pointer and the read that is in flight.
    logic [FW-1:0] r_ptr;
    logic          r_rvld;
    logic [IW-1:0] r_ridx;

    // The request being worked on.
    logic                    r_op;
    t_key                    r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;

    // Cache bookkeeping and configuration.
    logic [FW-1:0]      r_fill;
    logic [FW-1:0]      n_fill;
    logic [STAMP_W-1:0] r_stamp;
    logic [STAMP_W-1:0] n_stamp;
    logic [CNT_W-1:0]   r_hit;
    logic [CNT_W-1:0]   n_hit;
    logic [CNT_W-1:0]   r_miss;
    logic [CNT_W-1:0]   n_miss;
    logic [CAP_W-1:0]   r_cap;

    // Response register.
    logic                    r_out_vld;
    logic                    r_out_found;
    logic [PAYLOAD_BITS-1:0] r_out_pay;
    logic [CNT_W-1:0]        r_out_hit;
    logic [CNT_W-1:0]        r_out_miss;

    // Sequencer outputs.
    logic      accept;
    logic      rd_en;
    logic      commit;
    logic      wr_en;
    t_scan_ctl scan_ctl;

    // RAM and scan unit signals.
    logic [WORD_W-1:0]       rd_word;
    logic [WORD_W-1:0]       wr_word;
    logic [IW-1:0]           wr_addr;
    t_key                    ent_key;
    logic [STAMP_W-1:0]      ent_stamp;
    logic [PAYLOAD_BITS-1:0] ent_payload;
    logic                    hit_found;
    logic [IW-1:0]           hit_idx;
    logic [PAYLOAD_BITS-1:0] hit_payload;
    logic [IW-1:0]           victim_idx;

    // Decision helpers.
    logic               scan_more;
    logic               out_free;
    logic [CMPW-1:0]    cap_x;
    logic [CMPW-1:0]    cap_eff;
    logic               fill_room;
    logic [STAMP_W-1:0] stamp_inc;
    logic               is_lookup;

    assign scan_more = (r_ptr != r_fill);
    assign out_free  = !r_out_vld || o_rsp.ready;
    assign is_lookup = (r_op == OP_LOOKUP);
    assign stamp_inc = r_stamp + STAMP_W'(1);

    // Effective capacity: zero means one, anything above the slot count means all slots.
    assign cap_x = CMPW'(r_cap);
    always_comb begin
        priority if (cap_x == '0) begin
            cap_eff = CMPW'(1);
        end else if (cap_x > CMPW'(ENTRIES)) begin
            cap_eff = CMPW'(ENTRIES);
        end else begin
            cap_eff = cap_x;
        end
    end
    assign fill_room = (CMPW'(r_fill) < cap_eff);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Leave once every filled entry has been read and compared.
                if (!scan_more && !r_rvld) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_req.ready    = 1'b0;
        rd_en          = 1'b0;
        scan_ctl.clear = 1'b0;
        scan_ctl.cmp   = 1'b0;
        commit         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready    = 1'b1;
                scan_ctl.clear = 1'b1;
            end
            ST_SCAN: begin
                rd_en        = scan_more;
                scan_ctl.cmp = r_rvld;
            end
            ST_DECIDE: begin
                commit = out_free;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    assign accept = i_req.valid && i_req.ready;
    assign wr_en  = commit && (r_op == OP_UPDATE);

    // Slot to write: the matching entry, else the next free slot, else the oldest entry.
    always_comb begin
        priority if (hit_found) begin
            wr_addr = hit_idx;
        end else if (fill_room) begin
            wr_addr = r_fill[IW-1:0];
        end else begin
            wr_addr = victim_idx;
        end
    end

    assign wr_word = {r_key, stamp_inc, r_pay};
    assign {ent_key, ent_stamp, ent_payload} = rd_word;

    // Next values of the bookkeeping registers.
    always_comb begin
        n_hit   = r_hit;
        n_miss  = r_miss;
        n_fill  = r_fill;
        n_stamp = r_stamp;
        if (commit && is_lookup) begin
            if (hit_found && (r_hit != CNT_MAX)) begin
                n_hit = r_hit + CNT_W'(1);
            end
            if (!hit_found && (r_miss != CNT_MAX)) begin
                n_miss = r_miss + CNT_W'(1);
            end
        end
        if (wr_en) begin
            n_stamp = stamp_inc;
            if (!hit_found && fill_room) begin
                n_fill = r_fill + FW'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ptr     <= '0;
            r_rvld    <= 1'b0;
            r_fill    <= '0;
            r_stamp   <= '0;
            r_hit     <= '0;
            r_miss    <= '0;
            r_cap     <= CAP_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rvld  <= rd_en;
            r_fill  <= n_fill;
            r_stamp <= n_stamp;
            r_hit   <= n_hit;
            r_miss  <= n_miss;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (accept) begin
                r_ptr <= '0;
            end else if (rd_en) begin
                r_ptr <= r_ptr + FW'(1);
            end
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op              <= i_req.opcode;
            r_key.nodes       <= i_req.key_node_count;
            r_key.live_bytes  <= i_req.key_live_bytes;
            r_key.matmuls     <= i_req.key_matmul_count;
            r_pay             <= i_req.payload_in;
        end
        if (rd_en) begin
            r_ridx <= r_ptr[IW-1:0];
        end
        if (commit) begin
            r_out_found <= hit_found;
            r_out_pay   <= (hit_found && is_lookup) ? hit_payload : '0;
            r_out_hit   <= n_hit;
            r_out_miss  <= n_miss;
        end
    end

    lsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .i_re    (rd_en),
        .i_raddr (r_ptr[IW-1:0]),
        .o_rdata (rd_word)
    );

    lsc_scan #(
        .IW           (IW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_idx         (r_ridx),
        .i_key         (r_key),
        .i_ent_key     (ent_key),
        .i_ent_stamp   (ent_stamp),
        .i_ent_payload (ent_payload),
        .o_found       (hit_found),
        .o_hit_idx     (hit_idx),
        .o_hit_payload (hit_payload),
        .o_victim_idx  (victim_idx)
    );

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.payload_out = r_out_pay;
    assign o_rsp.hit_total   = r_out_hit;
    assign o_rsp.miss_total  = r_out_miss;

endmodule

>>> tb/sv/lru_signature_cache_tb.sv
// Self-checking testbench of the LRU signature cache: directed and random request streams.
`timescale 1ns / 100ps

module lru_signature_cache_tb;
    import lsc_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int PAYLOAD_BITS = 64;
    // The slowest correct run stays far below this many cycles.
    localparam int CYCLE_LIMIT  = 500000;
    // The receiver holds off this long once, so that the block fills up and stalls.
    localparam int HOLD_CYCLES  = 250;
    // Wait after draining, long enough to cover any late response.
    localparam int SETTLE_CYCLES = 2 * (ENTRIES + 4);
    localparam int KEY_POOL     = 20;

    // What one response transaction carries, as the checker compares it.
    typedef struct packed {
        logic                    found;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [CNT_W-1:0]        hits;
        logic [CNT_W-1:0]        misses;
    } t_rsp_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lsc_req_if #(.PAYLOAD_BITS(PAYLOAD_BITS)) req_if ();
    lsc_rsp_if #(.PAYLOAD_BITS(PAYLOAD_BITS)) rsp_if ();

    lru_signature_cache #(
        .ENTRIES      (ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Our own copy of the cache contents. Only slots below slot_fill are ever read, so the
    // slots that were never written need no defined contents.
    t_key                    slot_key     [ENTRIES];
    logic [PAYLOAD_BITS-1:0] slot_payload [ENTRIES];
    logic [STAMP_W-1:0]      slot_stamp   [ENTRIES];
    int unsigned             slot_fill;
    logic [STAMP_W-1:0]      tick;
    logic [CNT_W-1:0]        hit_cnt;
    logic [CNT_W-1:0]        miss_cnt;
    logic [CAP_W-1:0]        capacity_reg;

    // Responses that the block owes us, oldest first.
    t_rsp_item pending_rsp[$];

    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_armed;

    t_key key_pool[KEY_POOL];

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // The run ends here if the block hangs somewhere.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Writes one slot the way the block does: every write takes the next tick as its stamp.
    function automatic void write_slot(int unsigned idx, t_key key,
                                       logic [PAYLOAD_BITS-1:0] payload);
        tick              = tick + 1'b1;
        slot_key[idx]     = key;
        slot_payload[idx] = payload;
        slot_stamp[idx]   = tick;
    endfunction

    // Applies one accepted request to our copy of the cache and returns the response
    // that the block must give for it.
    function automatic t_rsp_item cache_access(t_opcode op, t_key key,
                                               logic [PAYLOAD_BITS-1:0] payload);
        int          match_idx;
        int unsigned eff_cap;
        int unsigned victim;
        t_rsp_item   rsp;

        match_idx = -1;
        rsp       = '0;
        for (int i = 0; i < slot_fill; i++) begin
            if (match_idx < 0 && slot_key[i] == key) begin
                match_idx = i;
            end
        end

        // A capacity of zero acts as one, anything above the slot count as the slot count.
        if (capacity_reg == '0) begin
            eff_cap = 1;
        end else if (capacity_reg > ENTRIES) begin
            eff_cap = ENTRIES;
        end else begin
            eff_cap = capacity_reg;
        end

        if (op == OP_LOOKUP) begin
            // A lookup counts but never touches recency.
            if (match_idx >= 0) begin
                rsp.found   = 1'b1;
                rsp.payload = slot_payload[match_idx];
                if (hit_cnt != CNT_MAX) begin
                    hit_cnt = hit_cnt + 1'b1;
                end
            end else if (miss_cnt != CNT_MAX) begin
                miss_cnt = miss_cnt + 1'b1;
            end
        end else if (match_idx >= 0) begin
            rsp.found = 1'b1;
            write_slot(match_idx, key, payload);
        end else if (slot_fill < eff_cap) begin
            write_slot(slot_fill, key, payload);
            slot_fill = slot_fill + 1;
        end else begin
            // The oldest stamp goes; on a tie the lowest index wins. Entries filled before
            // the capacity was lowered still take part.
            victim = 0;
            for (int i = 1; i < slot_fill; i++) begin
                if (slot_stamp[i] < slot_stamp[victim]) begin
                    victim = i;
                end
            end
            write_slot(victim, key, payload);
        end

        rsp.hits   = hit_cnt;
        rsp.misses = miss_cnt;
        return rsp;
    endfunction

    function automatic t_key make_key(logic [NODE_W-1:0] nodes, logic [BYTE_W-1:0] bytes_live,
                                      logic [MM_W-1:0] matmuls);
        t_key k;
        k.nodes      = nodes;
        k.live_bytes = bytes_live;
        k.matmuls    = matmuls;
        return k;
    endfunction

    function automatic t_key random_key();
        return make_key(16'($urandom), {16'($urandom), $urandom}, 16'($urandom));
    endfunction

    // Offers one request transaction, possibly after random idle cycles, and records the
    // expected response once the block takes it. Called and left at a falling edge; valid
    // stays high on return so that back-to-back requests need no gap.
    task automatic send_req(t_opcode op, t_key key, logic [PAYLOAD_BITS-1:0] payload);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid            <= 1'b1;
        req_if.opcode           <= op;
        req_if.key_node_count   <= key.nodes;
        req_if.key_live_bytes   <= key.live_bytes;
        req_if.key_matmul_count <= key.matmuls;
        req_if.payload_in       <= payload;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        pending_rsp = {pending_rsp, cache_access(op, key, payload)};
        @(negedge i_clk);
    endtask

    // Stops offering requests and waits until every owed response has been taken.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Writes the capacity register. The block is idle here because every request gives
    // exactly one response and all of them have been taken.
    task automatic set_capacity(logic [CAP_W-1:0] value);
        wait_drained();
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= value;
        capacity_reg  = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Lookups into the empty cache after reset must all miss, with the key at its extremes.
    task automatic test_empty_lookups();
        send_req(OP_LOOKUP, make_key('0, '0, '0), '1);
        send_req(OP_LOOKUP, make_key('1, '1, '1), '0);
    endtask

    // Fills two entries, hits both, refreshes one in place and checks that a key that
    // differs in only one field does not match.
    task automatic test_fill_and_refresh();
        send_req(OP_UPDATE, make_key('0, '0, '0), '1);
        send_req(OP_UPDATE, make_key('1, '1, '1), '0);
        send_req(OP_LOOKUP, make_key('0, '0, '0), 64'h5a5a_5a5a_5a5a_5a5a);
        send_req(OP_LOOKUP, make_key('1, '1, '1), '0);
        send_req(OP_UPDATE, make_key('0, '0, '0), 64'h0123_4567_89ab_cdef);
        send_req(OP_LOOKUP, make_key('0, '0, '0), '0);
        send_req(OP_LOOKUP, make_key('1, '1, 16'hfffe), '0);
    endtask

    // With a small capacity the entry with the oldest stamp goes, and a lookup hit must
    // not save an entry from eviction.
    task automatic test_eviction();
        set_capacity(5'd3);
        send_req(OP_UPDATE, make_key(16'h8000, 48'h8000_0000_0000, 16'h8000),
                 64'h8000_0000_0000_0001);
        send_req(OP_LOOKUP, make_key('1, '1, '1), '0);
        send_req(OP_UPDATE, make_key(16'h0001, 48'h0000_0000_0001, 16'h0001),
                 64'hffff_0000_ffff_0000);
        send_req(OP_LOOKUP, make_key('1, '1, '1), '0);
        send_req(OP_LOOKUP, make_key('0, '0, '0), '0);
    endtask

    // Capacity zero acts as one, lowering below the fill level keeps the filled entries
    // matchable, and the largest write value acts as the slot count.
    task automatic test_capacity_extremes();
        set_capacity(5'd0);
        send_req(OP_UPDATE, make_key(16'h1234, 48'h5678_9abc_def0, 16'h4321),
                 64'haaaa_5555_aaaa_5555);
        send_req(OP_LOOKUP, make_key(16'h8000, 48'h8000_0000_0000, 16'h8000), '0);
        set_capacity(5'd31);
        send_req(OP_UPDATE, make_key(16'h7fff, 48'h7fff_ffff_ffff, 16'h7fff),
                 64'h7fff_ffff_ffff_ffff);
        send_req(OP_LOOKUP, make_key(16'h7fff, 48'h7fff_ffff_ffff, 16'h7fff), '0);
        set_capacity(CAP_RESET);
    endtask

    // Random traffic in a few capacity settings. Most keys come from a small pool so that
    // hits, refreshes and evictions are common; the rest are keys that differ from a pool
    // key in one bit, and keys that are random throughout.
    task automatic run_random_phase(int sender_pct, int receiver_pct, int n_items);
        int          span;
        int          pick;
        t_key        key;
        t_opcode     op;
        logic [CAP_W-1:0] cap;

        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int sub = 0; sub < 3; sub++) begin
            unique case (sub)
                0: begin
                    cap = 5'($urandom_range(0, 31));
                end
                1: begin
                    cap = 5'($urandom_range(1, 4));
                end
                default: begin
                    pick = $urandom_range(0, 3);
                    cap  = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd16 : (pick == 2) ? 5'd31
                         : 5'($urandom_range(5, 15));
                end
            endcase
            set_capacity(cap);
            span = $urandom_range(2, KEY_POOL);
            for (int n = 0; n < n_items / 3; n++) begin
                pick = $urandom_range(0, 99);
                key  = key_pool[$urandom_range(0, span - 1)];
                if (pick >= 85) begin
                    key = random_key();
                end else if (pick >= 70) begin
                    key = key ^ (t_key'(1) << $urandom_range(0, KEY_W - 1));
                end
                op = ($urandom_range(0, 99) < 45) ? OP_UPDATE : OP_LOOKUP;
                send_req(op, key, {$urandom, $urandom});
            end
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = random_key();
        end
        run_random_phase(33, 73, 345);
        run_random_phase(73, 33, 345);
        run_random_phase(0, 0, 345);
    endtask

    // The receiver stops taking responses for a long stretch while the sender keeps
    // offering requests back to back, so the output register fills and the block stops
    // taking requests. Afterwards the sender pauses until everything has drained.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed    = 1'b1;
        for (int n = 0; n < 8; n++) begin
            send_req((n % 2 == 0) ? OP_UPDATE : OP_LOOKUP, key_pool[n % 3],
                     {$urandom, $urandom});
        end
        wait_drained();
    endtask

    // Response side: random ready at the falling edge, with one long hold-off on request.
    initial begin : rsp_sink
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Every response transaction is compared, field by field, with the oldest expectation.
    always @(posedge i_clk) begin : rsp_check
        t_rsp_item want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                $error("response transaction with no request outstanding");
                mismatch_count = mismatch_count + 1;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, rsp_if.found);
                    mismatch_count = mismatch_count + 1;
                end
                if (rsp_if.payload_out !== want.payload) begin
                    $error("payload_out: expected %h, actual %h", want.payload,
                           rsp_if.payload_out);
                    mismatch_count = mismatch_count + 1;
                end
                if (rsp_if.hit_total !== want.hits) begin
                    $error("hit_total: expected %0d, actual %0d", want.hits, rsp_if.hit_total);
                    mismatch_count = mismatch_count + 1;
                end
                if (rsp_if.miss_total !== want.misses) begin
                    $error("miss_total: expected %0d, actual %0d", want.misses,
                           rsp_if.miss_total);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    initial begin : main_seq
        // Every input known from time zero; the cache copy starts as the block does.
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_wdata             = '0;
        req_if.valid            = 1'b0;
        req_if.opcode           = OP_LOOKUP;
        req_if.key_node_count   = '0;
        req_if.key_live_bytes   = '0;
        req_if.key_matmul_count = '0;
        req_if.payload_in       = '0;
        slot_fill               = 0;
        tick                    = '0;
        hit_cnt                 = '0;
        miss_cnt                = '0;
        capacity_reg            = CAP_RESET;
        send_idle_pct           = 33;
        recv_idle_pct           = 73;
        hold_armed              = 1'b0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_lookups();
        test_fill_and_refresh();
        test_eviction();
        test_capacity_extremes();
        test_random();
        test_backpressure();

        // Anything the block sends after this point has no request behind it.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
